FILE: hw/rtl/vcfr_pkg.sv
// Shared types and constants of the voice command frame receiver.
package vcfr_pkg;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef enum logic {
      REG_COMMAND_MIN = 1'b0,
      REG_COMMAND_MAX = 1'b1
   } reg_index_type;

   localparam logic [7:0] START_A = 8'hAA;
   localparam logic [7:0] START_B = 8'h55;
   localparam logic [7:0] COMMAND_MIN_RESET = 8'h01;
   localparam logic [7:0] COMMAND_MAX_RESET = 8'h0E;
   localparam int MIN_FRAME = 5;

endpackage

FILE: hw/rtl/vcfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module vcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hw/rtl/voice_command_frame_receiver.sv
// Top level of the voice command frame receiver.
//
//   Channel   Direction  Handshake                         Payload
//   req       in         req_valid / req_ready             kind, rx_byte, read_index
//   rsp       out        rsp_valid / rsp_ready             ready_res, byte_count,
//                                                          read_data, dropped
//   csr       in/out     psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// One item is accepted per cycle while req_ready is high, then held in the stage register.
// State is updated at the acceptance edge, and the buffer read data is registered once
// in the RAM before it reaches the result register.
// Reset is synchronous; it clears the fill count, the ready flag, both pipeline valids
// and restores the command range registers. The buffer contents are not cleared.
// A stalled result holds the stage behind it, and req_ready drops only when both are full.
module voice_command_frame_receiver import vcfr_pkg::*; #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_rx_byte,
   input  logic [5:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ready_res,
   output logic [6:0]  rsp_byte_count,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_dropped,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int ADDR_W = $clog2(BUFFER_DEPTH);
   localparam int COUNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BUFFER_DEPTH);
   localparam logic [COUNT_W-1:0] CHECK_COUNT = COUNT_W'(MIN_FRAME - 1);

   typedef struct packed {
      logic       ready;
      logic [6:0] count;
      logic       read_hit;
      logic       from_first;
      logic [7:0] first;
      logic       dropped;
   } stage_type;

   logic [7:0]         command_min_ff;
   logic [7:0]         command_max_ff;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic               ready_ff, ready_in;
   logic [7:0]         first_ff, first_in;
   logic [7:0]         second_ff, second_in;
   logic [7:0]         last_ff, last_in;
   logic               stage_valid_ff;
   stage_type          stage_ff, stage_in;
   logic               rsp_valid_ff;
   logic               rsp_ready_res_ff;
   logic [6:0]         rsp_byte_count_ff;
   logic [7:0]         rsp_read_data_ff;
   logic               rsp_dropped_ff;

   logic               accept;
   logic               advance;
   logic               take;
   logic               dropped;
   logic               read_hit;
   logic               wr_en;
   logic [7:0]         ram_q;
   logic               csr_write;
   reg_index_type      csr_index;

   function automatic logic is_command(input logic [7:0] b, input logic [7:0] lo,
                                       input logic [7:0] hi);
      return (b >= lo) && (b <= hi);
   endfunction

   assign advance = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign accept = req_valid && req_ready;
   assign read_hit = accept && (kind_type'(req_kind) == KIND_READ)
                     && (int'(req_read_index) < BUFFER_DEPTH);

   always_comb begin
      fill_in = fill_ff;
      ready_in = ready_ff;
      first_in = first_ff;
      second_in = second_ff;
      last_in = last_ff;
      wr_en = 1'b0;
      take = 1'b0;
      dropped = 1'b0;
      if (accept) begin
         unique case (kind_type'(req_kind))
            KIND_BYTE: begin
               if (ready_ff) begin
                  dropped = 1'b1;
               end else if (fill_ff == '0) begin
                  take = 1'b1;
               end else if (fill_ff == FULL_COUNT) begin
                  fill_in = '0;
               end else begin
                  wr_en = 1'b1;
                  last_in = req_rx_byte;
                  fill_in = fill_ff + COUNT_W'(1);
                  if (fill_ff == COUNT_W'(1)) begin
                     second_in = req_rx_byte;
                     if (first_ff == START_A && req_rx_byte != START_B) begin
                        take = 1'b1;
                     end
                  end
                  if (fill_ff >= CHECK_COUNT && first_ff == START_A && second_ff == START_B
                      && last_ff == START_B && req_rx_byte == START_A) begin
                     ready_in = 1'b1;
                  end
               end
            end
            KIND_CLEAR: begin
               ready_in = 1'b0;
               fill_in = '0;
            end
            default: begin
            end
         endcase
         if (take) begin
            fill_in = '0;
            if (req_rx_byte == START_A) begin
               first_in = req_rx_byte;
               last_in = req_rx_byte;
               fill_in = COUNT_W'(1);
            end else if (is_command(req_rx_byte, command_min_ff, command_max_ff)) begin
               first_in = req_rx_byte;
               last_in = req_rx_byte;
               fill_in = COUNT_W'(1);
               ready_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      stage_in.ready = ready_in;
      stage_in.count = 7'(fill_in);
      stage_in.read_hit = read_hit;
      stage_in.from_first = (req_read_index == '0);
      stage_in.first = first_ff;
      stage_in.dropped = dropped;
   end

   vcfr_ram #(
      .WIDTH(8),
      .DEPTH(BUFFER_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(ADDR_W'(fill_ff)),
      .wr_data(req_rx_byte),
      .rd_en  (read_hit),
      .rd_addr(ADDR_W'(req_read_index)),
      .rd_data(ram_q)
   );

   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[2]);
   assign pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         REG_COMMAND_MIN: prdata = {24'd0, command_min_ff};
         REG_COMMAND_MAX: prdata = {24'd0, command_max_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_min_ff <= COMMAND_MIN_RESET;
         command_max_ff <= COMMAND_MAX_RESET;
         fill_ff <= '0;
         ready_ff <= 1'b0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_COMMAND_MIN: command_min_ff <= pwdata[7:0];
               REG_COMMAND_MAX: command_max_ff <= pwdata[7:0];
               default: begin
               end
            endcase
         end
         fill_ff <= fill_in;
         ready_ff <= ready_in;
         if (accept) begin
            stage_valid_ff <= 1'b1;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      second_ff <= second_in;
      last_ff <= last_in;
      if (accept) begin
         stage_ff <= stage_in;
      end
      if (advance) begin
         rsp_ready_res_ff <= stage_ff.ready;
         rsp_byte_count_ff <= stage_ff.count;
         rsp_dropped_ff <= stage_ff.dropped;
         if (stage_ff.read_hit) begin
            rsp_read_data_ff <= stage_ff.from_first ? stage_ff.first : ram_q;
         end else begin
            rsp_read_data_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ready_res = rsp_ready_res_ff;
   assign rsp_byte_count = rsp_byte_count_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_dropped = rsp_dropped_ff;

endmodule

FILE: hw/rtl/vcfr_checker.sv
// Port-level checker of the voice command frame receiver and its bind statement.
module vcfr_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ready_res,
   input logic [6:0]  rsp_byte_count,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_dropped
);

   // A byte is discarded only while ready is set, and discarding leaves ready set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_ready_res)
      else $error("dropped byte reported without ready");

   // A discarded byte never carries read data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_read_data == 8'd0)
      else $error("dropped byte reported with read data");

   // No result can be pending in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result transfer holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ready_res)
         && $stable(rsp_byte_count) && $stable(rsp_read_data) && $stable(rsp_dropped))
      else $error("stalled result changed");

   // The input is held off only while a result is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input held off without a stalled result");

endmodule

bind voice_command_frame_receiver vcfr_port_checker u_vcfr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_ready_res (rsp_ready_res),
   .rsp_byte_count(rsp_byte_count),
   .rsp_read_data (rsp_read_data),
   .rsp_dropped   (rsp_dropped)
);

FILE: test/vcfr_checker.sv
// Checker that predicts every result of the voice command frame receiver and compares it.
module vcfr_checker import vcfr_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [1:0]       req_kind,
   input  logic [7:0]       req_rx_byte,
   input  logic [5:0]       req_read_index,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             rsp_ready_res,
   input  logic [6:0]       rsp_byte_count,
   input  logic [7:0]       rsp_read_data,
   input  logic             rsp_dropped,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   input  logic             pready,
   output int               mismatch_count,
   output int               outstanding,
   output logic [DEPTH-1:0] stored_mask
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       ready;
      logic [6:0] count;
      logic [7:0] data;
      logic       dropped;
   } frame_status_t;

   logic [7:0]    frame_bytes [DEPTH];
   int unsigned   fill;
   logic          frame_ready;
   logic [7:0]    command_lo;
   logic [7:0]    command_hi;
   frame_status_t pending_status [$];

   // Judges a byte as the first one of an empty buffer.
   function automatic void open_frame(input logic [7:0] b);
      if (b == START_A || (b >= command_lo && b <= command_hi)) begin
         frame_bytes[0] = b;
         stored_mask[0] = 1'b1;
         fill = 1;
         if (b != START_A) frame_ready = 1'b1;
      end
   endfunction

   function automatic frame_status_t advance_receiver(input logic [1:0] kind,
                                                      input logic [7:0] b,
                                                      input logic [5:0] index);
      frame_status_t status;
      status.data = '0;
      status.dropped = 1'b0;
      case (kind)
         KIND_BYTE: begin
            if (frame_ready) begin
               status.dropped = 1'b1;
            end else if (fill == 0) begin
               open_frame(b);
            end else begin
               if (fill < DEPTH) begin
                  frame_bytes[fill] = b;
                  stored_mask[fill] = 1'b1;
                  fill++;
               end else begin
                  fill = 0;
               end
               if (fill == 2 && frame_bytes[0] == START_A && frame_bytes[1] != START_B) begin
                  fill = 0;
                  open_frame(frame_bytes[1]);
               end else if (fill >= MIN_FRAME && frame_bytes[0] == START_A
                            && frame_bytes[1] == START_B && frame_bytes[fill - 2] == START_B
                            && frame_bytes[fill - 1] == START_A) begin
                  frame_ready = 1'b1;
               end
            end
         end
         KIND_CLEAR: begin
            frame_ready = 1'b0;
            fill = 0;
         end
         KIND_READ: begin
            if (index < DEPTH) status.data = frame_bytes[index];
         end
         default: ;
      endcase
      status.ready = frame_ready;
      status.count = 7'(fill);
      return status;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         if (mismatch_count < 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      frame_status_t want;
      if (reset) begin
         fill = 0;
         frame_ready = 1'b0;
         command_lo = COMMAND_MIN_RESET;
         command_hi = COMMAND_MAX_RESET;
         stored_mask = '0;
         pending_status.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_status.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: result transfer with no result expected", $time);
               mismatch_count++;
            end else begin
               want = pending_status.pop_front();
               check_field("ready_res", 8'(want.ready), 8'(rsp_ready_res));
               check_field("byte_count", 8'(want.count), 8'(rsp_byte_count));
               check_field("read_data", want.data, rsp_read_data);
               check_field("dropped", 8'(want.dropped), 8'(rsp_dropped));
            end
         end
         if (req_valid && req_ready)
            pending_status.push_back(advance_receiver(req_kind, req_rx_byte, req_read_index));
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[2]))
               REG_COMMAND_MIN: command_lo = pwdata[7:0];
               REG_COMMAND_MAX: command_hi = pwdata[7:0];
               default: ;
            endcase
         end
         outstanding <= pending_status.size();
      end
   end

endmodule

FILE: test/tb_voice_command_frame_receiver.sv
// Testbench top of the voice command frame receiver: stimulus, idling and the verdict.
module tb_voice_command_frame_receiver import vcfr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int LONG_HOLD = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASE_ITEMS = 255;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [1:0]       req_kind;
   logic [7:0]       req_rx_byte;
   logic [5:0]       req_read_index;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_ready_res;
   logic [6:0]       rsp_byte_count;
   logic [7:0]       rsp_read_data;
   logic             rsp_dropped;
   logic             psel;
   logic             penable;
   logic             pwrite;
   logic [2:0]       paddr;
   logic [31:0]      pwdata;
   logic [31:0]      prdata;
   logic             pready;
   int               mismatch_count;
   int               outstanding;
   logic [DEPTH-1:0] stored_mask;

   int unsigned items_sent;
   int unsigned quiet_cycles;
   logic [7:0]  cmd_lo;
   logic [7:0]  cmd_hi;
   bit          sender_idling;
   bit          receiver_idling;
   bit          hold_request;

   voice_command_frame_receiver #(.BUFFER_DEPTH(DEPTH)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_rx_byte    (req_rx_byte),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ready_res  (rsp_ready_res),
      .rsp_byte_count (rsp_byte_count),
      .rsp_read_data  (rsp_read_data),
      .rsp_dropped    (rsp_dropped),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   vcfr_checker #(.DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_rx_byte    (req_rx_byte),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ready_res  (rsp_ready_res),
      .rsp_byte_count (rsp_byte_count),
      .rsp_read_data  (rsp_read_data),
      .rsp_dropped    (rsp_dropped),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .stored_mask    (stored_mask)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (psel && penable && pwrite && pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Result side: random stall bursts, plus one long hold that backs the block up.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (receiver_idling && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [1:0] kind, input logic [7:0] rx,
                            input logic [5:0] index);
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_rx_byte <= rx;
      req_read_index <= index;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(KIND_BYTE, b, 6'($urandom_range(0, DEPTH - 1)));
   endtask

   task automatic send_clear();
      send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, DEPTH - 1)));
   endtask

   // Reads only entries that have been written at least once.
   task automatic send_read();
      logic [5:0] slot;
      slot = 6'($urandom_range(0, DEPTH - 1));
      if (stored_mask == '0) begin
         send_clear();
      end else begin
         while (!stored_mask[slot]) slot++;
         send_item(KIND_READ, 8'($urandom_range(0, 255)), slot);
      end
   endtask

   task automatic write_register(input reg_index_type which, input logic [7:0] value);
      logic [31:0] noise;
      noise = $urandom();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {which, 2'b00};
      pwdata <= {noise[31:8], value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic close_sequence();
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) send_read();
      if ($urandom_range(0, 4) != 0) send_clear();
   endtask

   task automatic run_sequence();
      int unsigned choice;
      int unsigned len;
      logic [7:0]  b;
      logic [1:0]  k;
      choice = $urandom_range(0, 99);
      if (choice < 35) begin
         send_byte(START_A);
         send_byte(START_B);
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(58, 66) : $urandom_range(0, 8);
         repeat (len) send_byte(8'($urandom_range(0, 255)));
         send_byte(START_B);
         send_byte(START_A);
         close_sequence();
      end else if (choice < 55) begin
         if (cmd_lo <= cmd_hi) b = 8'($urandom_range(cmd_hi, cmd_lo));
         else b = 8'($urandom_range(0, 255));
         send_byte(b);
         close_sequence();
      end else if (choice < 70) begin
         send_byte(START_A);
         do b = 8'($urandom_range(0, 255)); while (b == START_B);
         send_byte(b);
         repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
         close_sequence();
      end else if (choice < 85) begin
         repeat ($urandom_range(1, 4)) send_read();
         send_clear();
      end else begin
         repeat ($urandom_range(1, 6)) begin
            k = 2'($urandom_range(0, 3));
            if (k == KIND_READ) send_read();
            else send_item(k, 8'($urandom_range(0, 255)), 6'($urandom_range(0, DEPTH - 1)));
         end
      end
   endtask

   initial begin
      int unsigned target;
      req_valid = 1'b0;
      req_kind = KIND_BYTE;
      req_rx_byte = '0;
      req_read_index = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      reset = 1'b1;
      items_sent = 0;
      quiet_cycles = 0;
      sender_idling = 1'b1;
      receiver_idling = 1'b1;
      hold_request = 1'b0;
      cmd_lo = COMMAND_MIN_RESET;
      cmd_hi = COMMAND_MAX_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Bytes just outside and at both ends of the reset command range.
      send_byte(8'h00);
      send_byte(8'h0F);
      send_byte(8'h01);
      send_byte(START_A);
      send_item(KIND_READ, 8'h00, 6'd0);
      send_clear();
      send_byte(8'h0E);
      send_clear();
      // A second byte other than the start pattern is judged again as a first byte.
      send_byte(START_A);
      send_byte(8'h07);
      send_clear();
      send_byte(START_A);
      send_byte(START_A);
      send_byte(START_B);
      send_byte(8'h80);
      send_byte(START_B);
      send_byte(START_A);
      send_byte(8'hFF);
      send_item(KIND_READ, 8'hFF, 6'd4);
      send_item(KIND_UNUSED, 8'hFF, 6'd63);
      send_clear();
      // Four bytes carry both patterns but are too short to complete a frame.
      send_byte(START_A);
      send_byte(START_B);
      send_byte(START_B);
      send_byte(START_A);
      send_clear();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            req_valid <= 1'b0;
            wait (outstanding == 0);
            @(negedge clock);
            case (phase)
               1: begin
                  cmd_lo = 8'h00;
                  cmd_hi = 8'hFF;
               end
               2: begin
                  cmd_lo = 8'hFF;
                  cmd_hi = 8'h00;
               end
               3: begin
                  cmd_lo = 8'h00;
                  cmd_hi = 8'h00;
               end
               4: begin
                  cmd_lo = 8'hFF;
                  cmd_hi = 8'hFF;
               end
               default: begin
                  cmd_lo = 8'($urandom_range(0, 255));
                  cmd_hi = 8'($urandom_range(0, 255));
               end
            endcase
            write_register(REG_COMMAND_MIN, cmd_lo);
            write_register(REG_COMMAND_MAX, cmd_hi);
         end
         if (phase == 1) hold_request = 1'b1;
         if (phase == 5) receiver_idling = 1'b0;
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            sender_idling = (phase < 5) && ($urandom_range(0, 3) != 0);
            run_sequence();
         end
      end
      req_valid <= 1'b0;

      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
